[rtl/min_merge_cost_heap_macros.svh]
// Assertion helpers shared by the checker.
`ifndef MIN_MERGE_COST_HEAP_MACROS_SVH
`define MIN_MERGE_COST_HEAP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define MMCH_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define MMCH_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/mmch_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mmch_pkg;

  // Port widths fixed by the interface
  localparam int LENGTH_W = 16;
  localparam int COST_W   = 32;

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  // Defaults for the top-level parameters
  localparam int DEFAULT_HEAP_DEPTH  = 256;
  localparam int DEFAULT_LENGTH_BITS = 16;

endpackage

`default_nettype wire

[rtl/mmch_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module mmch_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/min_merge_cost_heap.sv]
`timescale 1ns / 1ps
`default_nettype none

// Optimal merge (Huffman) cost of a set of lengths, built on a min-heap in one RAM.
// Request channel: drive length and last with start; a request is taken on a clock
// edge where start is high and busy is low. A zero length is ignored; a length that
// finds the heap full is dropped and reported with capacity_exceeded.
// Result channel: after the request marked last, done pulses for one cycle with
// total_cost, cost_saturated and capacity_exceeded. The receiver cannot stall; a
// result must be captured in its cycle. Requests without last give no result.
// Loading: a load into a nonempty heap compares against the parent and climbs one heap
// level per compare until it settles; a load into an empty or full heap needs no compare.
// The merge uses one RAM read port: each removal reads the root and the last entry,
// then sifts the moved entry down, reading and comparing the children of each level,
// and writes it where it settles; each merge step is two removals, a sum, one
// reinsertion and a check, repeated count - 1 times.
// The result is registered in the check state after the last merge step; busy is high throughout.
// Reset (synchronous, rst high) empties the heap and clears cost and flags; heap
// RAM contents are not cleared, since only entries below the fill count are read.
module min_merge_cost_heap #(
  parameter int HEAP_DEPTH  = mmch_pkg::DEFAULT_HEAP_DEPTH,
  parameter int LENGTH_BITS = mmch_pkg::DEFAULT_LENGTH_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [mmch_pkg::LENGTH_W-1:0] length,
  input  wire logic                        last,
  output logic                             busy,
  output logic                             done,
  output logic      [mmch_pkg::COST_W-1:0] total_cost,
  output logic                             cost_saturated,
  output logic                             capacity_exceeded
);

  import mmch_pkg::*;

  localparam int IDX_W   = $clog2(HEAP_DEPTH);
  localparam int CNT_W   = $clog2(HEAP_DEPTH + 1);
  localparam int CMP_W   = IDX_W + 2;
  localparam int ENTRY_W = LENGTH_BITS + IDX_W;
  localparam int LEN_USE = (LENGTH_BITS < LENGTH_W) ? LENGTH_BITS : LENGTH_W;
  localparam int SUM_W   = ((ENTRY_W > COST_W) ? ENTRY_W : COST_W) + 1;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(HEAP_DEPTH);
  localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(COST_MAX);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_START,
    S_INS_CMP,
    S_INS_PUT,
    S_MERGE_CHK,
    S_TK_RD,
    S_TK_TOP,
    S_TK_MOVED,
    S_SD_START,
    S_SD_LEFT,
    S_SD_RIGHT,
    S_SD_CMP,
    S_SUM
  } state_t;

  state_t state, state_next;

  logic [CNT_W-1:0]   count;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   child_idx;
  logic [ENTRY_W-1:0] child_val;
  logic [ENTRY_W-1:0] ins_val;
  logic [ENTRY_W-1:0] moved;
  logic [ENTRY_W-1:0] val_a;
  logic [ENTRY_W-1:0] val_b;
  logic               take_sel;
  logic               last_r;
  logic [COST_W-1:0]  acc;
  logic               sat;
  logic               dropped;

  // RAM port
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic [ENTRY_W-1:0] len_in;
  logic [IDX_W-1:0]   count_idx;
  logic [IDX_W-1:0]   ins_parent;
  logic [IDX_W-1:0]   parent_idx;
  logic [IDX_W-1:0]   gparent_idx;
  logic [CMP_W-1:0]   child_l;
  logic [CMP_W-1:0]   child_r;
  logic [CMP_W-1:0]   cnt_ext;
  logic [ENTRY_W-1:0] sum_ab;
  logic [SUM_W-1:0]   acc_sum;
  logic               ins_le;
  logic               sd_le;
  logic               ins_done;
  logic               take_done;

  mmch_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (HEAP_DEPTH)
  ) u_heap_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Index arithmetic of the heap tree
  assign len_in      = ENTRY_W'(length[LEN_USE-1:0]);
  assign count_idx   = count[IDX_W-1:0];
  assign ins_parent  = IDX_W'((count_idx - IDX_W'(1)) >> 1);
  assign parent_idx  = IDX_W'((idx - IDX_W'(1)) >> 1);
  assign gparent_idx = IDX_W'((parent_idx - IDX_W'(1)) >> 1);
  assign child_l     = {1'b0, idx, 1'b1};
  assign child_r     = child_l + CMP_W'(1);
  assign cnt_ext     = CMP_W'(count);

  // Shared compares and the merge adder
  assign ins_le  = (ram_rdata <= ins_val);
  assign sd_le   = (moved <= child_val);
  assign sum_ab  = val_a + val_b;
  assign acc_sum = SUM_W'(acc) + SUM_W'(sum_ab);

  assign busy = (state != S_IDLE);

  // Sequence the heap operations and drive the RAM
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = idx;
    ram_wdata  = ins_val;
    ram_raddr  = '0;
    ins_done   = 1'b0;
    take_done  = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (len_in != '0) begin
            state_next = S_INS_START;
          end else if (last) begin
            state_next = S_MERGE_CHK;
          end
        end
      end
      S_INS_START: begin
        if (count == DEPTH_C) begin
          ins_done = 1'b1;
        end else if (count == '0) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ins_done  = 1'b1;
        end else begin
          ram_raddr  = ins_parent;
          state_next = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        ram_we = 1'b1;
        if (ins_le) begin
          ins_done = 1'b1;
        end else begin
          // Pull the parent down and climb one level
          ram_wdata = ram_rdata;
          if (parent_idx == '0) begin
            state_next = S_INS_PUT;
          end else begin
            ram_raddr = gparent_idx;
          end
        end
      end
      S_INS_PUT: begin
        ram_we   = 1'b1;
        ins_done = 1'b1;
      end
      S_MERGE_CHK: begin
        if (count >= CNT_W'(2)) begin
          state_next = S_TK_RD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_TK_RD: begin
        ram_raddr  = '0;
        state_next = S_TK_TOP;
      end
      S_TK_TOP: begin
        if (count == '0) begin
          take_done = 1'b1;
        end else begin
          ram_raddr  = count_idx;
          state_next = S_TK_MOVED;
        end
      end
      S_TK_MOVED: begin
        state_next = S_SD_START;
      end
      S_SD_START: begin
        if (child_l >= cnt_ext) begin
          ram_we    = 1'b1;
          ram_wdata = moved;
          take_done = 1'b1;
        end else begin
          ram_raddr  = child_l[IDX_W-1:0];
          state_next = S_SD_LEFT;
        end
      end
      S_SD_LEFT: begin
        if (child_r < cnt_ext) begin
          ram_raddr  = child_r[IDX_W-1:0];
          state_next = S_SD_RIGHT;
        end else begin
          state_next = S_SD_CMP;
        end
      end
      S_SD_RIGHT: begin
        state_next = S_SD_CMP;
      end
      S_SD_CMP: begin
        ram_we = 1'b1;
        if (sd_le) begin
          ram_wdata = moved;
          take_done = 1'b1;
        end else begin
          ram_wdata  = child_val;
          state_next = S_SD_START;
        end
      end
      S_SUM: begin
        state_next = S_INS_START;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (ins_done) begin
      state_next = last_r ? S_MERGE_CHK : S_IDLE;
    end
    if (take_done) begin
      state_next = take_sel ? S_SUM : S_TK_RD;
    end
  end

  // Hold state, heap bookkeeping, cost and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      acc      <= '0;
      sat      <= 1'b0;
      dropped  <= 1'b0;
      done     <= 1'b0;
      take_sel <= 1'b0;
      last_r   <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (take_done) begin
        take_sel <= !take_sel;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            ins_val <= len_in;
            last_r  <= last;
          end
        end
        S_INS_START: begin
          if (count == DEPTH_C) begin
            dropped <= 1'b1;
          end else begin
            idx   <= count_idx;
            count <= count + CNT_W'(1);
          end
        end
        S_INS_CMP: begin
          if (!ins_le) begin
            idx <= parent_idx;
          end
        end
        S_MERGE_CHK: begin
          if (count < CNT_W'(2)) begin
            // Emit the result and drop the set
            done              <= 1'b1;
            total_cost        <= acc;
            cost_saturated    <= sat;
            capacity_exceeded <= dropped;
            count             <= '0;
            acc               <= '0;
            sat               <= 1'b0;
            dropped           <= 1'b0;
          end
        end
        S_TK_RD: begin
          count <= count - CNT_W'(1);
        end
        S_TK_TOP: begin
          if (take_sel) begin
            val_b <= ram_rdata;
          end else begin
            val_a <= ram_rdata;
          end
        end
        S_TK_MOVED: begin
          moved <= ram_rdata;
          idx   <= '0;
        end
        S_SD_LEFT: begin
          child_val <= ram_rdata;
          child_idx <= child_l[IDX_W-1:0];
        end
        S_SD_RIGHT: begin
          if (ram_rdata < child_val) begin
            child_val <= ram_rdata;
            child_idx <= child_r[IDX_W-1:0];
          end
        end
        S_SD_CMP: begin
          if (!sd_le) begin
            idx <= child_idx;
          end
        end
        S_SUM: begin
          // Accumulate with saturation, then reinsert the merged length
          if (sat || (acc_sum > SUM_MAX)) begin
            acc <= COST_MAX;
            sat <= 1'b1;
          end else begin
            acc <= acc_sum[COST_W-1:0];
          end
          ins_val <= sum_ab;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/mmch_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "min_merge_cost_heap_macros.svh"

module mmch_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          start,
  input wire logic [mmch_pkg::LENGTH_W-1:0] length,
  input wire logic                          last,
  input wire logic                          busy,
  input wire logic                          done,
  input wire logic [mmch_pkg::COST_W-1:0]   total_cost,
  input wire logic                          cost_saturated,
  input wire logic                          capacity_exceeded
);

  import mmch_pkg::*;

  // A result only follows a cycle of work
  `MMCH_ASSERT_NOW(a_done_after_busy, clk, rst, done, $past(busy), "result without work")

  // An accepted request never sees a result in the next cycle
  `MMCH_ASSERT_NEXT(a_no_done_after_req, clk, rst, start && !busy, !done, "result right after request")

  // A zero length without last leaves the block idle
  `MMCH_ASSERT_NEXT(a_zero_len_idle, clk, rst, start && !busy && (length == '0) && !last, !busy, "zero length made work")

  // A saturated cost reads as the maximum
  `MMCH_ASSERT_NOW(a_sat_max, clk, rst, done && cost_saturated, total_cost == COST_MAX, "saturated cost not at max")

  // The result strobe lasts one cycle
  `MMCH_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done, "result strobe held")

endmodule

bind min_merge_cost_heap mmch_checker u_mmch_checker (.*);

`default_nettype wire
